FILE: src/dpw_pkg.sv
// Shared widths, register codes and stage types for the depth pixel to world point block.
`default_nettype none
package dpw_pkg;

  localparam int COL_W     = 12;
  localparam int ROW_W     = 12;
  localparam int DEPTH_W   = 20;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 32;
  localparam int OUT_W     = 32;
  localparam int INV_W     = 24;
  localparam int CTR_W     = 16;
  localparam int HOR_W     = 40;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 20'd500000;

  localparam int POSE_N   = 12;
  localparam int POSE_TX  = 9;
  localparam logic signed [VAL_W-1:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FX  = 3'd0,
    REG_INV_FY  = 3'd1,
    REG_CX      = 3'd2,
    REG_CY      = 3'd3,
    REG_HORIZON = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [INV_W-1:0] inv_fx;
    logic [INV_W-1:0] inv_fy;
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;
  } intrinsics_t;

  // camera-space point: x, y in mm after rounding, z is the depth
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [20:0] z;
  } cam_pt_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } world_pt_t;

endpackage
`default_nettype wire

FILE: src/dpw_pixel_if.sv
// Input channel: depth pixels and pose entry loads.
`default_nettype none
interface dpw_pixel_if;
  import dpw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [COL_W-1:0]        col;
  logic [ROW_W-1:0]        row;
  logic [DEPTH_W-1:0]      depth_mm;
  logic [IDX_W-1:0]        entry_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source (
    output valid, func, col, row, depth_mm, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, func, col, row, depth_mm, entry_index, entry_value,
    output ready
  );
endinterface
`default_nettype wire

FILE: src/dpw_point_if.sv
// Output channel: world points.
`default_nettype none
interface dpw_point_if;
  import dpw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] world_x;
  logic signed [OUT_W-1:0] world_y;
  logic signed [OUT_W-1:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface
`default_nettype wire

FILE: src/dpw_backproject.sv
// Four-stage pinhole back-projection of a depth pixel into camera space.
`default_nettype none
module dpw_backproject (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [dpw_pkg::COL_W-1:0]     col,
  input  logic [dpw_pkg::ROW_W-1:0]     row,
  input  logic [dpw_pkg::DEPTH_W-1:0]   depth_mm,
  input  dpw_pkg::intrinsics_t          intr,
  output logic                          cam_valid,
  output dpw_pkg::cam_pt_t              cam,
  output logic                          busy
);
  import dpw_pkg::*;

  logic signed [17:0] dx_c, dy_c;
  logic               pix_ok;

  logic                     v1, v2, v3;
  logic signed [17:0]       dx1, dy1;
  logic [DEPTH_W-1:0]       dep1, dep2, dep3;
  logic signed [38:0]       px2, py2;
  logic signed [51:0]       mxl3, mxh3, myl3, myh3;
  logic signed [63:0]       fx, fy, rx, ry;

  assign dx_c = $signed({2'b00, col, 4'b0000}) - $signed({2'b00, intr.cx});
  assign dy_c = $signed({2'b00, row, 4'b0000}) - $signed({2'b00, intr.cy});
  assign pix_ok = (depth_mm != '0) && (depth_mm < DEPTH_LIMIT)
                  && (32'(col) < MAX_COLUMNS) && (32'(row) < MAX_ROWS);

  // recombine the two partial products, then round half away from zero by 2^-28
  always_comb begin
    fx = (64'(mxh3) <<< 12) + 64'(mxl3);
    fy = (64'(myh3) <<< 12) + 64'(myl3);
    rx = fx + (fx[63] ? 64'sd134217727 : 64'sd134217728);
    ry = fy + (fy[63] ? 64'sd134217727 : 64'sd134217728);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      cam_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid && pix_ok;
      v2        <= v1;
      v3        <= v2;
      cam_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1   <= dx_c;
      dy1   <= dy_c;
      dep1  <= depth_mm;
      px2   <= dx1 * $signed({1'b0, dep1});
      py2   <= dy1 * $signed({1'b0, dep1});
      dep2  <= dep1;
      // split the reciprocal into 12-bit halves to keep the multipliers narrow
      mxl3  <= px2 * $signed({1'b0, intr.inv_fx[11:0]});
      mxh3  <= px2 * $signed({1'b0, intr.inv_fx[23:12]});
      myl3  <= py2 * $signed({1'b0, intr.inv_fy[11:0]});
      myh3  <= py2 * $signed({1'b0, intr.inv_fy[23:12]});
      dep3  <= dep2;
      cam.x <= 34'(rx >>> 28);
      cam.y <= 34'(ry >>> 28);
      cam.z <= $signed({1'b0, dep3});
    end
  end

  assign busy = v1 | v2 | v3 | cam_valid;

endmodule
`default_nettype wire

FILE: src/dpw_transform.sv
// Six-stage pose transform, horizon test and saturation to world coordinates.
`default_nettype none
module dpw_transform (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 cam_valid,
  input  dpw_pkg::cam_pt_t                     cam,
  input  logic signed [dpw_pkg::VAL_W-1:0]     pose [dpw_pkg::POSE_N],
  input  logic [dpw_pkg::HOR_W-1:0]            horizon_sq,
  output logic                                 pt_valid,
  output dpw_pkg::world_pt_t                   pt,
  output logic                                 busy
);
  import dpw_pkg::*;

  logic                    v5, v6, v7, v8, v9;
  logic signed [65:0]      prod5 [9];
  logic signed [67:0]      acc6 [3];
  logic signed [37:0]      r7 [3];
  logic [20:0]             mag8 [3];
  logic signed [OUT_W-1:0] w8 [3];
  logic [41:0]             sq9 [3];
  logic signed [OUT_W-1:0] w9 [3];

  logic signed [33:0]      cam_v [3];
  logic signed [67:0]      rnd [3];
  logic signed [37:0]      a_abs [3];
  logic signed [38:0]      wsum [3];
  logic [2:0]              over;
  logic signed [OUT_W-1:0] wsat [3];
  logic [43:0]             dist_sum;

  assign cam_v[0] = cam.x;
  assign cam_v[1] = cam.y;
  assign cam_v[2] = 34'(cam.z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // round half away from zero by 2^-30
      rnd[i]   = acc6[i] + (acc6[i][67] ? 68'sd536870911 : 68'sd536870912);
      a_abs[i] = r7[i][37] ? -r7[i] : r7[i];
      over[i]  = a_abs[i] > 38'sd1048576;
      wsum[i]  = 39'(r7[i]) + 39'(pose[POSE_TX + i]);
      if (wsum[i] > 39'sd2147483647) begin
        wsat[i] = 32'sh7FFF_FFFF;
      end else if (wsum[i] < -39'sd2147483648) begin
        wsat[i] = 32'sh8000_0000;
      end else begin
        wsat[i] = 32'(wsum[i]);
      end
    end
    dist_sum = 44'(sq9[0]) + 44'(sq9[1]) + 44'(sq9[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5       <= 1'b0;
      v6       <= 1'b0;
      v7       <= 1'b0;
      v8       <= 1'b0;
      v9       <= 1'b0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      v5       <= cam_valid;
      v6       <= v5;
      v7       <= v6;
      v8       <= v7 && (over == 3'b000);
      v9       <= v8;
      pt_valid <= v9 && (dist_sum <= 44'(horizon_sq));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod5[i*3 + j] <= pose[i*3 + j] * cam_v[j];
        end
        acc6[i] <= 68'(prod5[i*3]) + 68'(prod5[i*3 + 1]) + 68'(prod5[i*3 + 2]);
        r7[i]   <= 38'(rnd[i] >>> 30);
        mag8[i] <= a_abs[i][20:0];
        w8[i]   <= wsat[i];
        sq9[i]  <= mag8[i] * mag8[i];
        w9[i]   <= w8[i];
      end
      pt.x <= w9[0];
      pt.y <= w9[1];
      pt.z <= w9[2];
    end
  end

  assign busy = v5 | v6 | v7 | v8 | v9 | pt_valid;

endmodule
`default_nettype wire

FILE: src/depth_pixel_to_world_point_top.sv
// Top level: configuration and pose registers, back-projection and transform pipeline, output skid.
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+------------
//  pixel    | in  | func, col, row, depth_mm, entry_index, entry_val | valid/ready
//  point    | out | world_x, world_y, world_z                        | valid/ready
//  cfg      | in  | cfg_index, cfg_data                              | cfg_write
//
// One pixel per cycle while the output skid is empty; a kept point passes through the
// 10 pipeline stages and then the output register. A pose load waits until the
// pipeline has drained so that earlier pixels keep the old pose.
// Reset restores the register defaults and the identity pose and empties the pipeline.
// A stalled point parks in a one-word skid; the pipeline halts only while it is full.
`default_nettype none
module depth_pixel_to_world_point_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpw_pkg::CFG_W-1:0]        cfg_data,
  dpw_pixel_if.sink                        pixel,
  dpw_point_if.source                      point
);
  import dpw_pkg::*;

  intrinsics_t             intr;
  logic [HOR_W-1:0]        horizon_sq;
  logic signed [VAL_W-1:0] pose [POSE_N];

  logic       adv;
  logic       bp_busy, tf_busy;
  logic       pix_take, load_take;
  logic       cam_valid;
  cam_pt_t    cam;
  logic       pipe_valid;
  world_pt_t  pipe_pt;
  logic       push, pop;
  logic       out_valid, skid_valid;
  world_pt_t  out_pt, skid_pt;

  assign adv          = !skid_valid;
  assign pixel.ready  = adv && ((pixel.func == FUNC_PIXEL) || !(bp_busy || tf_busy));
  assign pix_take     = pixel.valid && pixel.ready && (pixel.func == FUNC_PIXEL);
  assign load_take    = pixel.valid && pixel.ready && (pixel.func == FUNC_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      intr.inv_fx <= 24'd16384;
      intr.inv_fy <= 24'd16384;
      intr.cx     <= 16'd5120;
      intr.cy     <= 16'd3840;
      horizon_sq  <= 40'd25000000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INV_FX:  intr.inv_fx <= cfg_data[INV_W-1:0];
        REG_INV_FY:  intr.inv_fy <= cfg_data[INV_W-1:0];
        REG_CX:      intr.cx     <= cfg_data[CTR_W-1:0];
        REG_CY:      intr.cy     <= cfg_data[CTR_W-1:0];
        REG_HORIZON: horizon_sq  <= cfg_data[HOR_W-1:0];
        default: ;
      endcase
    end
  end

  // pose entries; out-of-range indexes match nothing and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POSE_N; i++) begin
        pose[i] <= ((i == 0) || (i == 4) || (i == 8)) ? ONE_Q30 : '0;
      end
    end else if (load_take) begin
      for (int i = 0; i < POSE_N; i++) begin
        if (pixel.entry_index == IDX_W'(i)) begin
          pose[i] <= pixel.entry_value;
        end
      end
    end
  end

  dpw_backproject u_backproject (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pix_take),
    .col       (pixel.col),
    .row       (pixel.row),
    .depth_mm  (pixel.depth_mm),
    .intr      (intr),
    .cam_valid (cam_valid),
    .cam       (cam),
    .busy      (bp_busy)
  );

  dpw_transform u_transform (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cam_valid  (cam_valid),
    .cam        (cam),
    .pose       (pose),
    .horizon_sq (horizon_sq),
    .pt_valid   (pipe_valid),
    .pt         (pipe_pt),
    .busy       (tf_busy)
  );

  assign push = pipe_valid && adv;
  assign pop  = out_valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_pt <= skid_valid ? skid_pt : pipe_pt;
    end else if (push) begin
      skid_pt <= pipe_pt;
    end
  end

  assign point.valid   = out_valid;
  assign point.world_x = out_pt.x;
  assign point.world_y = out_pt.y;
  assign point.world_z = out_pt.z;

endmodule
`default_nettype wire
